@@ sv/pcin_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pcin_pkg;
  localparam int MaxPoints = 64;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = IdxW + 1;
  localparam logic [31:0] Deg2RadQ32 = 32'd74961321;
  localparam logic [31:0] PiQ29 = 32'd1686629713;
  localparam logic [31:0] HalfPiQ29 = 32'd843314856;
  localparam logic [25:0] TwoPiQ23 = 26'd52707179;
  localparam logic [30:0] OneQ30 = 31'h4000_0000;
  localparam logic [47:0] SumMax = 48'hFFFF_FFFF_FFFF;

  // Divisors of the Horner form of the sine series, innermost first.
  function automatic logic [7:0] horner_div(input logic [2:0] i);
    case (i)
      3'd0: horner_div = 8'd156;
      3'd1: horner_div = 8'd110;
      3'd2: horner_div = 8'd72;
      3'd3: horner_div = 8'd42;
      3'd4: horner_div = 8'd20;
      default: horner_div = 8'd6;
    endcase
  endfunction

  // ceil(2^s / d) for each Horner divisor d; (n * recip) >> s is floor(n / d)
  // for any 32-bit n.
  function automatic logic [32:0] horner_recip(input logic [2:0] i);
    case (i)
      3'd0: horner_recip = 33'd7048151461;
      3'd1: horner_recip = 33'd4997780127;
      3'd2: horner_recip = 33'd7635497416;
      3'd3: horner_recip = 33'd6544712071;
      3'd4: horner_recip = 33'd6871947674;
      default: horner_recip = 33'd5726623062;
    endcase
  endfunction

  function automatic logic [5:0] horner_shift(input logic [2:0] i);
    case (i)
      3'd0: horner_shift = 6'd40;
      3'd1: horner_shift = 6'd39;
      3'd2: horner_shift = 6'd39;
      3'd3: horner_shift = 6'd38;
      3'd4: horner_shift = 6'd37;
      default: horner_shift = 6'd35;
    endcase
  endfunction

  typedef enum logic [4:0] {
    S_IDLE, S_RAD, S_RED, S_X2, S_HMUL, S_HDIV, S_SIN, S_P, S_YHI, S_Y,
    S_AREA_HI, S_AREA_LO, S_ACC, S_DIV, S_EMIT
  } pcin_state_e;

  typedef struct packed {
    logic        busy;
    logic [IdxW-1:0] idx;
  } pcin_stat_t;
endpackage
`default_nettype wire

@@ sv/psf_cumulative_integral_normalizer.sv @@
// Cumulative trapezoid integral of a radial profile, normalized to its total.
// Input channel (in_valid_i/in_stall_o): one point per item, angle sep_deg_i
// (Q8.16 deg), density psf_value_i (Q16.16), last_point_i closes the run.
// Output channel (out_valid_o/out_stall_i): on the last point, one item per
// stored point: point_index_o, partial_norm_o (Q1.30), total_integral_o,
// truncated_o, last_of_run_o on the final item.
// One 33x33 multiplier serves every product; the Horner divisions by
// constants run on it as reciprocal multiplies. A stored point holds the input
// through rad, reduce, x^2, six Horner multiply/divide pairs, sine, three
// weight products, two area partial products and accumulate; the first point
// of a run skips the area. A dropped point holds it only through rad. On the
// last point each result is issued to the radix-2 divider, computed there and
// then handed over, one stored point after another, and receiver stalls
// lengthen the drain. in_stall_o is high for all of that.
// A stalled output holds its item in the output register; the sequencer
// waits there. Reset clears the run state and the sequencer; the integral
// memory is not cleared, since a run reads only the entries it wrote.
// Throughput is one item at a time; the next point is taken when the block
// has returned to idle.
`timescale 1ns / 1ps
`default_nettype none
module psf_cumulative_integral_normalizer import pcin_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [23:0] sep_deg_i,
  input  wire logic [31:0] psf_value_i,
  input  wire logic        last_point_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [5:0]       point_index_o,
  output logic [30:0]      partial_norm_o,
  output logic [47:0]      total_integral_o,
  output logic             truncated_o,
  output logic             last_of_run_o
);
  pcin_state_e st_q, st_d;
  logic [47:0] mem [MaxPoints];
  logic [47:0] rd_q;

  logic [23:0] deg_q;
  logic [31:0] psf_q;
  logic        last_q;
  logic [31:0] rad_q, prev_rad_q, x_q;
  logic        neg_q;
  logic [31:0] x2_q, t_q;
  logic [2:0]  hi_q;
  logic [63:0] acc_q;
  logic [48:0] prev_w_q, y_q;
  logic [47:0] sum_q;
  logic [CntW-1:0] cnt_q, k_q;
  logic        ovf_q;
  logic [47:0] am_q;
  logic [33:0] dm_q;
  logic        aneg_q;
  logic [65:0] hi_prod_q;

  // Shared multiplier.
  logic [32:0] ma, mb;
  logic [65:0] mp;
  assign mp = ma * mb;

  logic in_acc, out_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o = (st_q != S_IDLE);

  logic        div_start, div_done;
  logic [30:0] div_q;
  pcin_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(rd_q), .den_i(sum_q),
    .done_o(div_done), .quot_o(div_q)
  );

  logic [IdxW-1:0] k_idx, rd_addr;
  assign k_idx = k_q[IdxW-1:0];
  // Read ahead on a handover so the next divide starts on the next entry.
  assign rd_addr = out_acc ? k_idx + 1'b1 : k_idx;

  // Area operands
  logic signed [33:0] dd;
  assign dd = $signed({2'b0, rad_q}) - $signed({2'b0, prev_rad_q});

  logic [32:0] h_recip;
  logic [5:0]  h_sh;
  assign h_recip = horner_recip(hi_q);
  assign h_sh = horner_shift(hi_q);

  always_comb begin
    st_d = st_q;
    ma = '0;
    mb = '0;
    div_start = 1'b0;
    case (st_q)
      S_IDLE: if (in_acc) st_d = S_RAD;
      S_RAD: begin
        ma = {9'd0, deg_q};
        mb = {1'b0, Deg2RadQ32};
        st_d = (cnt_q == CntW'(MaxPoints)) ? (last_q ? S_DIV : S_IDLE) : S_RED;
        if (cnt_q == CntW'(MaxPoints) && last_q) div_start = 1'b0;
      end
      S_RED: st_d = S_X2;
      S_X2: begin
        ma = {x_q, 1'b0};
        mb = {x_q, 1'b0};
        st_d = S_HMUL;
      end
      S_HMUL: begin
        ma = {1'b0, x2_q};
        mb = {1'b0, t_q};
        st_d = S_HDIV;
      end
      S_HDIV: begin
        ma = {1'b0, acc_q[61:30]};
        mb = h_recip;
        st_d = (hi_q == 3'd5) ? S_SIN : S_HMUL;
      end
      S_SIN: begin
        ma = {x_q, 1'b0};
        mb = {1'b0, t_q};
        st_d = S_P;
      end
      S_P: begin
        ma = {1'b0, psf_q};
        mb = {1'b0, t_q};
        st_d = S_YHI;
      end
      S_YHI: begin
        ma = {9'd0, acc_q[39:16]};
        mb = {7'd0, TwoPiQ23};
        st_d = S_Y;
      end
      S_Y: begin
        ma = {17'd0, acc_q[15:0]};
        mb = {7'd0, TwoPiQ23};
        st_d = (cnt_q == '0) ? S_ACC : S_AREA_HI;
      end
      S_AREA_HI: begin
        ma = {1'b0, am_q[47:16]};
        mb = dm_q[32:0];
        st_d = S_AREA_LO;
      end
      S_AREA_LO: begin
        ma = {17'd0, am_q[15:0]};
        mb = dm_q[32:0];
        st_d = S_ACC;
      end
      S_ACC: st_d = last_q ? S_DIV : S_IDLE;
      S_DIV: begin
        div_start = 1'b1;
        st_d = S_EMIT;
      end
      S_EMIT: begin
        if (div_done || (out_valid_o && out_acc)) st_d = S_EMIT;
        if (out_acc) st_d = last_of_run_o ? S_IDLE : S_DIV;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      sum_q <= '0;
      prev_w_q <= '0;
      prev_rad_q <= '0;
      out_valid_o <= 1'b0;
      k_q <= '0;
    end else begin
      st_q <= st_d;
      if (out_acc) out_valid_o <= 1'b0;
      else if (div_done) out_valid_o <= 1'b1;
      case (st_q)
        S_RAD: if (cnt_q == CntW'(MaxPoints)) begin
          ovf_q <= 1'b1;
          k_q <= '0;
        end
        S_ACC: begin
          prev_rad_q <= rad_q;
          prev_w_q <= y_q;
          cnt_q <= cnt_q + 1'b1;
          k_q <= '0;
          if (cnt_q != '0) sum_q <= am_q;
        end
        S_EMIT: if (out_acc) begin
          k_q <= k_q + 1'b1;
          if (last_of_run_o) begin
            cnt_q <= '0;
            ovf_q <= 1'b0;
            sum_q <= '0;
            prev_w_q <= '0;
            prev_rad_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  logic [65:0] h_quot;
  logic [31:0] tq;
  logic [65:0] ysum;
  logic [47:0] y_mag;
  logic [47:0] vm;
  logic signed [49:0] ns;
  always_comb begin
    h_quot = mp >> h_sh;
    tq = h_quot[31:0];
    ysum = {hi_prod_q[49:0], 16'd0} + {24'd0, mp[41:0]};
    y_mag = ysum[65:18];
    vm = 48'(hi_prod_q[65:14] + (((52'(hi_prod_q[13:0]) << 16) + 52'(mp)) >> 30));
    ns = $signed({2'b0, sum_q}) + (aneg_q ? -$signed({2'b0, vm}) : $signed({2'b0, vm}));
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      deg_q <= sep_deg_i;
      psf_q <= psf_value_i;
      last_q <= last_point_i;
    end
    case (st_q)
      S_RAD: rad_q <= mp[50:19];
      S_RED: begin
        logic [31:0] xv;
        xv = rad_q;
        neg_q <= rad_q >= PiQ29;
        if (rad_q >= PiQ29) xv = rad_q - PiQ29;
        if (xv > HalfPiQ29) xv = PiQ29 - xv;
        x_q <= xv;
      end
      S_X2: begin
        x2_q <= mp[61:30];
        t_q <= {1'b0, OneQ30};
        hi_q <= '0;
      end
      S_HMUL: acc_q <= mp[63:0];
      S_HDIV: begin
        t_q <= {1'b0, OneQ30} - tq;
        hi_q <= hi_q + 3'd1;
      end
      S_SIN: t_q <= mp[61:30];
      S_P: acc_q <= {24'd0, mp[63:24]};
      S_Y: y_q <= neg_q ? -{1'b0, y_mag} : {1'b0, y_mag};
      default: ;
    endcase
    if (st_q == S_Y) begin
      logic [48:0] yv, sv;
      yv = neg_q ? -{1'b0, y_mag} : {1'b0, y_mag};
      sv = prev_w_q + yv;
      am_q <= sv[48] ? 48'(-sv) : sv[47:0];
      dm_q <= dd[33] ? 34'(-dd) : 34'(dd);
      aneg_q <= sv[48] != dd[33];
    end
    if (st_q == S_YHI || st_q == S_AREA_HI) hi_prod_q <= mp;
    if (st_q == S_AREA_LO) begin
      if (ns < 0) am_q <= '0;
      else if (ns > $signed({2'b0, SumMax})) am_q <= SumMax;
      else am_q <= ns[47:0];
    end
    if (st_q == S_ACC) mem[cnt_q[IdxW-1:0]] <= (cnt_q == '0) ? 48'd0 : am_q;
    rd_q <= mem[rd_addr];
    if (div_done) begin
      point_index_o <= 6'(k_idx);
      partial_norm_o <= (sum_q == '0) ? 31'd0 : (rd_q >= sum_q) ? OneQ30 : div_q;
      total_integral_o <= sum_q;
      truncated_o <= ovf_q;
      last_of_run_o <= (k_q + 1'b1 == cnt_q);
    end
  end

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> in_stall_o) else $error("accepted while busy");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxPoints)) else $error("count past capacity");
  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (st_q == S_EMIT)) else $error("result outside drain");
`endif
endmodule
`default_nettype wire

@@ sv/pcin_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pcin_divider import pcin_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] num_i,
  input  wire logic [47:0] den_i,
  output logic             done_o,
  output logic [30:0]      quot_o
);
  logic [48:0] rem_q, rem_d;
  logic [29:0] q_q, q_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic [47:0] den_q;
  logic [49:0] sh;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_d = rem_q;
    q_d = q_q;
    cnt_d = cnt_q;
    run_d = run_q;
    sh = {rem_q, 1'b0};
    if (start_i) begin
      rem_d = {1'b0, num_i};
      q_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (sh >= {2'b0, den_q}) begin
        rem_d = 49'(sh - {2'b0, den_q});
        q_d = {q_q[28:0], 1'b1};
      end else begin
        rem_d = sh[48:0];
        q_d = {q_q[28:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd29) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q <= q_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = run_q && (cnt_q == 5'd29);
  assign quot_o = {1'b0, q_d};
endmodule
`default_nettype wire
